@@ rtl/mtc_pkg.sv @@
// Package for the mode transition controller: widths, operation and status
// codes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package mtc_pkg;

  localparam int NUM_MODES = 8;
  localparam int MODE_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int BLK_W     = 16;
  localparam int IDX_W     = 2 * MODE_W;
  localparam int TR_DEPTH  = 1 << IDX_W;
  localparam int TL_DEPTH  = 1 << MODE_W;
  localparam int OP_W      = 3;
  localparam int ST_W      = 3;

  localparam logic [BLK_W-1:0] NOT_DEFINED_INDEX = 16'hFFFF;

  localparam logic [OP_W-1:0] OP_SET_TL  = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_TR  = 3'd1;
  localparam logic [OP_W-1:0] OP_START   = 3'd2;
  localparam logic [OP_W-1:0] OP_FINISH  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST    = 3'd5;

  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_MODE    = 3'd1;
  localparam logic [ST_W-1:0] ST_INACTIVE    = 3'd3;
  localparam logic [ST_W-1:0] ST_BUSY        = 3'd4;
  localparam logic [ST_W-1:0] ST_ILLEGAL     = 3'd5;
  localparam logic [ST_W-1:0] ST_NOT_IN_PROG = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_LEMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic emit;
    logic idx_clr;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic list_scan;
    logic def_at_idx;
    logic last;
  } stat_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              deploy_valid;
    logic              tasklist_valid;
    logic [BLK_W-1:0]  block_out;
    logic              entry_valid;
    logic [MODE_W-1:0] entry_from;
    logic [MODE_W-1:0] entry_to;
    logic [MODE_W-1:0] current_mode;
    logic [MODE_W-1:0] previous_mode;
    logic              in_progress;
    logic              last;
  } res_t;

endpackage

@@ rtl/mtc_ctrl.sv @@
// Controller state machine for the mode transition controller.
// Depends on mtc_pkg; drives mtc_datapath through cmd_t, reads stat_t.
`timescale 1ns / 1ps

module mtc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  mtc_pkg::stat_t stat,
  output mtc_pkg::cmd_t  cmd
);

  mtc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtc_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = mtc_pkg::S_EXEC;
      end
      mtc_pkg::S_EXEC: begin
        state_nxt = stat.list_scan ? mtc_pkg::S_SCAN : mtc_pkg::S_OUT;
      end
      mtc_pkg::S_SCAN: begin
        if (stat.def_at_idx) state_nxt = mtc_pkg::S_LEMIT;
      end
      mtc_pkg::S_LEMIT: begin
        state_nxt = mtc_pkg::S_OUT;
      end
      mtc_pkg::S_OUT: begin
        if (out_tready) state_nxt = stat.last ? mtc_pkg::S_IDLE : mtc_pkg::S_SCAN;
      end
      default: begin
        state_nxt = mtc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      mtc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      mtc_pkg::S_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.idx_clr = 1'b1;
      end
      mtc_pkg::S_SCAN: begin
        cmd.idx_inc = !stat.def_at_idx;
      end
      mtc_pkg::S_LEMIT: begin
        cmd.emit = 1'b1;
      end
      mtc_pkg::S_OUT: begin
        out_tvalid  = 1'b1;
        cmd.idx_inc = out_tready && !stat.last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/mtc_datapath.sv @@
// Datapath for the mode transition controller: transition table memory with
// defined bits, task-list table, mode registers and the result register.
// Depends on mtc_pkg; commanded by mtc_ctrl.
`timescale 1ns / 1ps

module mtc_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mtc_pkg::cmd_t                     cmd,
  input  logic [mtc_pkg::OP_W-1:0]          in_op,
  input  logic [mtc_pkg::BYTE_W-1:0]        in_from,
  input  logic [mtc_pkg::BYTE_W-1:0]        in_to,
  input  logic [mtc_pkg::BLK_W-1:0]         in_blk,
  input  logic                              in_act,
  input  logic                              cfg_we,
  input  logic [mtc_pkg::MODE_W-1:0]        cfg_wdata,
  output mtc_pkg::stat_t                    stat,
  output mtc_pkg::res_t                     res
);

  logic [mtc_pkg::BLK_W-1:0]  tr_mem [mtc_pkg::TR_DEPTH];
  logic [mtc_pkg::BLK_W-1:0]  rd_r;
  logic [mtc_pkg::TR_DEPTH-1:0] def_r, def_nxt;
  logic [mtc_pkg::BLK_W-1:0]  tl_r [mtc_pkg::TL_DEPTH];

  logic [mtc_pkg::OP_W-1:0]   op_r;
  logic [mtc_pkg::BYTE_W-1:0] from_r, to_r;
  logic [mtc_pkg::BLK_W-1:0]  blk_r;
  logic                       act_r;
  logic [mtc_pkg::IDX_W-1:0]  addr_r, idx_r, rd_addr, wr_addr;

  logic [mtc_pkg::MODE_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic                       busy_r, busy_nxt;
  logic                       tl_we, tr_we;

  mtc_pkg::res_t              res_r, exec_res, emit_res;

  logic                       to_ok, from_ok, cur_ok;
  logic [mtc_pkg::ST_W-1:0]   chk;
  logic [mtc_pkg::MODE_W-1:0] tl_sel;
  logic [mtc_pkg::BLK_W-1:0]  tl_rd;
  logic [mtc_pkg::TR_DEPTH-1:0] above;

  assign to_ok   = to_r < mtc_pkg::BYTE_W'(mtc_pkg::NUM_MODES);
  assign from_ok = from_r < mtc_pkg::BYTE_W'(mtc_pkg::NUM_MODES);
  assign cur_ok  = {1'b0, cur_r} < (mtc_pkg::MODE_W + 1)'(mtc_pkg::NUM_MODES);
  assign chk     = (blk_r != mtc_pkg::NOT_DEFINED_INDEX && !act_r) ?
                   mtc_pkg::ST_INACTIVE : mtc_pkg::ST_OK;
  assign tl_sel  = (op_r == mtc_pkg::OP_FINISH) ? cur_r : to_r[mtc_pkg::MODE_W-1:0];
  assign tl_rd   = tl_r[tl_sel];
  assign rd_addr = cmd.latch ? {cur_r, in_to[mtc_pkg::MODE_W-1:0]} : idx_r;
  assign wr_addr = {from_r[mtc_pkg::MODE_W-1:0], to_r[mtc_pkg::MODE_W-1:0]};
  assign above   = (def_r >> idx_r) >> 1;

  // Transition table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && tr_we) tr_mem[wr_addr] <= blk_r;
    rd_r <= tr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      from_r <= in_from;
      to_r   <= in_to;
      blk_r  <= in_blk;
      act_r  <= in_act;
      addr_r <= rd_addr;
    end
  end

  always_comb begin
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    busy_nxt = busy_r;
    tl_we    = 1'b0;
    tr_we    = 1'b0;
    exec_res = '0;
    exec_res.last = 1'b1;
    case (op_r)
      mtc_pkg::OP_SET_TL: begin
        if (!to_ok) begin
          exec_res.status = mtc_pkg::ST_BAD_MODE;
        end else begin
          exec_res.status = chk;
          tl_we = (chk == mtc_pkg::ST_OK);
        end
      end
      mtc_pkg::OP_SET_TR: begin
        if (!to_ok || !from_ok) begin
          exec_res.status = mtc_pkg::ST_BAD_MODE;
        end else begin
          exec_res.status = chk;
          tr_we = (chk == mtc_pkg::ST_OK);
        end
      end
      mtc_pkg::OP_START: begin
        if (!to_ok) begin
          exec_res.status = mtc_pkg::ST_BAD_MODE;
        end else if (busy_r) begin
          exec_res.status = mtc_pkg::ST_BUSY;
        end else if (!cur_ok || !def_r[addr_r]) begin
          exec_res.status = mtc_pkg::ST_ILLEGAL;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = to_r[mtc_pkg::MODE_W-1:0];
          busy_nxt = 1'b1;
          exec_res.deploy_valid = 1'b1;
          exec_res.block_out    = rd_r;
        end
      end
      mtc_pkg::OP_FINISH: begin
        if (!busy_r) begin
          exec_res.status = mtc_pkg::ST_NOT_IN_PROG;
        end else begin
          busy_nxt = 1'b0;
          exec_res.tasklist_valid = 1'b1;
          exec_res.block_out      = cur_ok ? tl_rd : '0;
        end
      end
      mtc_pkg::OP_QUERY: begin
        if (!to_ok) begin
          exec_res.status = mtc_pkg::ST_BAD_MODE;
        end else begin
          exec_res.tasklist_valid = 1'b1;
          exec_res.block_out      = tl_rd;
        end
      end
      mtc_pkg::OP_LIST: begin
        exec_res.status = mtc_pkg::ST_OK;
      end
      default: begin
        exec_res.status = mtc_pkg::ST_BAD_MODE;
      end
    endcase
    exec_res.current_mode  = cur_nxt;
    exec_res.previous_mode = prev_nxt;
    exec_res.in_progress   = busy_nxt;
  end

  always_comb begin
    emit_res               = '0;
    emit_res.status        = mtc_pkg::ST_OK;
    emit_res.block_out     = rd_r;
    emit_res.entry_valid   = 1'b1;
    emit_res.entry_from    = idx_r[mtc_pkg::IDX_W-1:mtc_pkg::MODE_W];
    emit_res.entry_to      = idx_r[mtc_pkg::MODE_W-1:0];
    emit_res.current_mode  = cur_r;
    emit_res.previous_mode = prev_r;
    emit_res.in_progress   = busy_r;
    emit_res.last          = ~|above;
  end

  always_comb begin
    def_nxt = def_r;
    if (cmd.exec && tr_we) def_nxt[wr_addr] = (blk_r != mtc_pkg::NOT_DEFINED_INDEX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_r  <= '0;
      cur_r  <= '0;
      prev_r <= '0;
      busy_r <= 1'b0;
      idx_r  <= '0;
      for (int i = 0; i < mtc_pkg::TL_DEPTH; i++) tl_r[i] <= '0;
    end else begin
      def_r <= def_nxt;
      if (cfg_we) begin
        cur_r  <= cfg_wdata;
        prev_r <= cfg_wdata;
      end else if (cmd.exec) begin
        cur_r  <= cur_nxt;
        prev_r <= prev_nxt;
        busy_r <= busy_nxt;
      end
      if (cmd.exec && tl_we) tl_r[to_r[mtc_pkg::MODE_W-1:0]] <= blk_r;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (cmd.exec && !stat.list_scan) begin
      res_r <= exec_res;
    end else if (cmd.emit) begin
      res_r <= emit_res;
    end
  end

  assign stat.list_scan  = (op_r == mtc_pkg::OP_LIST) && (|def_r);
  assign stat.def_at_idx = def_r[idx_r];
  assign stat.last       = res_r.last;
  assign res             = res_r;

endmodule

@@ rtl/mode_transition_controller.sv @@
// Top level of the mode transition controller: stream ports and packing.
// Depends on mtc_pkg, mtc_ctrl and mtc_datapath.
//
// Usage:
//   One command beat enters on in_*; in_tuser carries the operation code.
//   Every command gives one result beat on out_*, except list, which gives
//   one beat for each defined transition entry (from-major, to-minor), or a
//   single empty beat when none is defined. out_tlast marks the final beat.
//   A single-entry command steps through accept, execute (table memory
//   read is registered) and result beat before the next accept when the
//   receiver is ready. List scans the table one entry per cycle up to the
//   last defined entry, but pauses at each listed entry for its read-out
//   and for its result beat, which waits for out_tready.
//   The result stays in its output register while out_tready is low; no
//   new command is taken until the last result beat of the current one goes.
//   Reset marks all transition entries undefined at once (one defined bit
//   per entry), clears the task lists and sets current and previous mode 0.
//   cfg_we loads current and previous mode from cfg_wdata; write it idle.
`timescale 1ns / 1ps

module mode_transition_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // from_mode[7:0], target_mode[15:8],
                                  // block_index[31:16], block_active[32], zero
  input  logic [2:0]  in_tuser,   // mode (operation)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status[2:0], block_out[18:3], entry_from[21:19],
                                  // entry_to[24:22], current_mode_out[27:25],
                                  // previous_mode_out[30:28], in_progress[31]
  output logic [2:0]  out_tuser,  // deploy_valid[0], tasklist_valid[1], entry_valid[2]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);

  mtc_pkg::cmd_t  cmd;
  mtc_pkg::stat_t stat;
  mtc_pkg::res_t  res;

  mtc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mtc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_op     (in_tuser),
    .in_from   (in_tdata[7:0]),
    .in_to     (in_tdata[15:8]),
    .in_blk    (in_tdata[31:16]),
    .in_act    (in_tdata[32]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .res       (res)
  );

  assign out_tdata = {res.in_progress, res.previous_mode, res.current_mode,
                      res.entry_to, res.entry_from, res.block_out, res.status};
  assign out_tuser = {res.entry_valid, res.tasklist_valid, res.deploy_valid};
  assign out_tlast = res.last;

endmodule

@@ test/mode_transition_controller_tb.sv @@
// Testbench for mode_transition_controller: directed and random command beats,
// checked beat by beat against an in-bench predictor of the mode tables.
// Depends on mtc_pkg and the mode_transition_controller RTL.
`timescale 1ns / 1ps

module mode_transition_controller_tb;
  import mtc_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] src_mode;
    logic [BYTE_W-1:0] dst_mode;
    logic [BLK_W-1:0]  blk;
    logic              act;
  } ctl_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;

  ctl_cmd_t cmd_q[$];
  ctl_cmd_t cmd_on_bus;
  res_t     expected_beats[$];

  logic [BLK_W-1:0]  tr_blk [TR_DEPTH];
  logic [BLK_W-1:0]  tl_blk [TL_DEPTH];
  logic [MODE_W-1:0] cur_m;
  logic [MODE_W-1:0] prev_m;
  logic              busy;

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  logic [15:0] rx_cycle = '0;
  logic pressure_req = 1'b0;
  logic pressure_done = 1'b0;
  int idle_cycles = 0;
  int fail_count = 0;
  logic [MODE_W-1:0] mode_guess;

  mode_transition_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ST_W-1:0] store_status(input logic [BLK_W-1:0] blk,
                                                   input logic act);
    return (blk != NOT_DEFINED_INDEX && !act) ? ST_INACTIVE : ST_OK;
  endfunction

  task automatic predict_command(input ctl_cmd_t c);
    res_t r;
    logic [BLK_W-1:0] e;
    logic [IDX_W-1:0] idx;
    int n;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    n = 0;
    case (c.op)
      OP_SET_TL: begin
        if (c.dst_mode >= NUM_MODES) begin
          r.status = ST_BAD_MODE;
        end else begin
          r.status = store_status(c.blk, c.act);
          if (r.status == ST_OK) tl_blk[c.dst_mode[2:0]] = c.blk;
        end
      end
      OP_SET_TR: begin
        if (c.src_mode >= NUM_MODES || c.dst_mode >= NUM_MODES) begin
          r.status = ST_BAD_MODE;
        end else begin
          r.status = store_status(c.blk, c.act);
          if (r.status == ST_OK) tr_blk[{c.src_mode[2:0], c.dst_mode[2:0]}] = c.blk;
        end
      end
      OP_START: begin
        e = tr_blk[{cur_m, c.dst_mode[2:0]}];
        if (c.dst_mode >= NUM_MODES) begin
          r.status = ST_BAD_MODE;
        end else if (busy) begin
          r.status = ST_BUSY;
        end else if (e == NOT_DEFINED_INDEX) begin
          r.status = ST_ILLEGAL;
        end else begin
          prev_m = cur_m;
          cur_m = c.dst_mode[2:0];
          busy = 1'b1;
          r.deploy_valid = 1'b1;
          r.block_out = e;
        end
      end
      OP_FINISH: begin
        if (!busy) begin
          r.status = ST_NOT_IN_PROG;
        end else begin
          busy = 1'b0;
          r.tasklist_valid = 1'b1;
          r.block_out = tl_blk[cur_m];
        end
      end
      OP_QUERY: begin
        if (c.dst_mode >= NUM_MODES) begin
          r.status = ST_BAD_MODE;
        end else begin
          r.tasklist_valid = 1'b1;
          r.block_out = tl_blk[c.dst_mode[2:0]];
        end
      end
      OP_LIST: begin
        for (int i = 0; i < TR_DEPTH; i++) begin
          idx = i[IDX_W-1:0];
          if (tr_blk[i] != NOT_DEFINED_INDEX) begin
            r.block_out = tr_blk[i];
            r.entry_valid = 1'b1;
            r.entry_from = idx[5:3];
            r.entry_to = idx[2:0];
            r.last = 1'b0;
            r.current_mode = cur_m;
            r.previous_mode = prev_m;
            r.in_progress = busy;
            expected_beats.push_back(r);
            n++;
          end
        end
        if (n > 0) expected_beats[$].last = 1'b1;
        r = '0;
        r.status = ST_OK;
        r.last = 1'b1;
      end
      default: r.status = ST_BAD_MODE;
    endcase
    if (c.op != OP_LIST || n == 0) begin
      r.current_mode = cur_m;
      r.previous_mode = prev_m;
      r.in_progress = busy;
      expected_beats.push_back(r);
    end
  endtask

  function automatic string res_str(input res_t r);
    return $sformatf("st=%0d dep=%0b tl=%0b blk=%h ev=%0b from=%0d to=%0d cur=%0d prev=%0d ip=%0b last=%0b",
                     r.status, r.deploy_valid, r.tasklist_valid, r.block_out, r.entry_valid,
                     r.entry_from, r.entry_to, r.current_mode, r.previous_mode, r.in_progress,
                     r.last);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin : driver
    logic taken;
    taken = in_tvalid && in_tready;
    if (taken) predict_command(cmd_on_bus);
    if (rst_n && (!in_tvalid || taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cmd_on_bus <= cmd_q[0];
        in_tdata <= {7'd0, cmd_q[0].act, cmd_q[0].blk, cmd_q[0].dst_mode, cmd_q[0].src_mode};
        in_tuser <= cmd_q[0].op;
        void'(cmd_q.pop_front());
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: rotating stall pattern, plus one long hold-off on request.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (pressure_req && !pressure_done) begin
      hold_left <= HOLD_CYCLES;
      pressure_done <= 1'b1;
      out_tready <= 1'b0;
    end else if (rx_cycle[7:6] == 2'd0) begin
      out_tready <= 1'b1;
    end else if (rx_cycle[7:6] == 2'd1) begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end else if (rx_cycle[7:6] == 2'd2) begin
      out_tready <= ($urandom_range(0, 3) == 0);
    end else begin
      out_tready <= rx_cycle[1];
    end
  end

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (out_tvalid && out_tready) begin
      got = '0;
      got.status = out_tdata[2:0];
      got.block_out = out_tdata[18:3];
      got.entry_from = out_tdata[21:19];
      got.entry_to = out_tdata[24:22];
      got.current_mode = out_tdata[27:25];
      got.previous_mode = out_tdata[30:28];
      got.in_progress = out_tdata[31];
      got.deploy_valid = out_tuser[0];
      got.tasklist_valid = out_tuser[1];
      got.entry_valid = out_tuser[2];
      got.last = out_tlast;
      if (expected_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result beat: %s", res_str(got));
      end else begin
        want = expected_beats.pop_front();
        if (got.status !== want.status || got.deploy_valid !== want.deploy_valid ||
            got.tasklist_valid !== want.tasklist_valid || got.block_out !== want.block_out ||
            got.entry_valid !== want.entry_valid || got.entry_from !== want.entry_from ||
            got.entry_to !== want.entry_to || got.current_mode !== want.current_mode ||
            got.previous_mode !== want.previous_mode ||
            got.in_progress !== want.in_progress || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", res_str(want));
            $display("  actual   %s", res_str(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic ctl_cmd_t mk(input logic [OP_W-1:0] op, input logic [7:0] src,
                                  input logic [7:0] dst, input logic [15:0] blk,
                                  input logic act);
    ctl_cmd_t c;
    c.op = op;
    c.src_mode = src;
    c.dst_mode = dst;
    c.blk = blk;
    c.act = act;
    return c;
  endfunction

  function automatic logic [7:0] pick_mode();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, NUM_MODES - 1));
    return 8'($urandom_range(NUM_MODES, 255));
  endfunction

  function automatic logic [15:0] pick_blk();
    if ($urandom_range(0, 99) < 12) return NOT_DEFINED_INDEX;
    return 16'($urandom);
  endfunction

  function automatic ctl_cmd_t rand_cmd(input logic [OP_W-1:0] op);
    return mk(op, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
  endfunction

  task automatic add_random(input int n);
    ctl_cmd_t c;
    int added;
    int kind;
    logic [7:0] dst;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        dst = pick_mode();
        if ($urandom_range(0, 1) == 1) begin
          c = rand_cmd(OP_SET_TR);
          c.src_mode = {5'd0, mode_guess};
          c.dst_mode = dst;
          c.blk = 16'($urandom_range(0, 16'hFFFE));
          c.act = 1'b1;
          cmd_q.push_back(c);
          added++;
        end
        c = rand_cmd(OP_START);
        c.dst_mode = dst;
        cmd_q.push_back(c);
        added++;
        if (dst < NUM_MODES) mode_guess = dst[2:0];
        if ($urandom_range(0, 4) != 0) begin
          cmd_q.push_back(rand_cmd(OP_FINISH));
          added++;
        end
      end else begin
        if (kind < 58) begin
          c = rand_cmd(OP_SET_TR);
          c.src_mode = pick_mode();
        end else if (kind < 70) begin
          c = rand_cmd(OP_SET_TL);
        end else if (kind < 78) begin
          c = rand_cmd(OP_QUERY);
        end else if (kind < 86) begin
          c = rand_cmd(OP_FINISH);
        end else if (kind < 92) begin
          c = rand_cmd(OP_START);
        end else if (kind < 97) begin
          c = rand_cmd(OP_LIST);
        end else begin
          c = rand_cmd($urandom_range(0, 1) ? OP_RSVD_7 : OP_RSVD_6);
        end
        if (c.op != OP_RSVD_6 && c.op != OP_RSVD_7) begin
          c.dst_mode = pick_mode();
          c.blk = pick_blk();
          c.act = ($urandom_range(0, 99) < 85);
        end
        cmd_q.push_back(c);
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_tvalid || expected_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_startup(input logic [MODE_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cur_m = v;
    prev_m = v;
    mode_guess = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < TR_DEPTH; i++) tr_blk[i] = NOT_DEFINED_INDEX;
    for (int i = 0; i < TL_DEPTH; i++) tl_blk[i] = '0;
    cur_m = '0;
    prev_m = '0;
    busy = 1'b0;
    mode_guess = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    write_startup(3'd7);
    cmd_q.push_back(mk(OP_LIST, 8'd0, 8'd0, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_QUERY, 8'd0, 8'd0, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_QUERY, 8'd0, 8'd7, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_QUERY, 8'd0, 8'd8, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_QUERY, 8'd0, 8'd255, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_FINISH, 8'd0, 8'd0, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_START, 8'd0, 8'd0, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_SET_TL, 8'd0, 8'd255, 16'd1, 1'b1));
    cmd_q.push_back(mk(OP_SET_TL, 8'd0, 8'd3, 16'h1234, 1'b0));
    cmd_q.push_back(mk(OP_SET_TL, 8'd0, 8'd3, NOT_DEFINED_INDEX, 1'b0));
    cmd_q.push_back(mk(OP_SET_TL, 8'd0, 8'd0, 16'h0000, 1'b1));
    cmd_q.push_back(mk(OP_SET_TL, 8'd0, 8'd7, 16'hFFFE, 1'b1));
    cmd_q.push_back(mk(OP_SET_TR, 8'd200, 8'd1, 16'h0001, 1'b1));
    cmd_q.push_back(mk(OP_SET_TR, 8'd1, 8'd9, 16'h0001, 1'b1));
    cmd_q.push_back(mk(OP_SET_TR, 8'd7, 8'd3, 16'hABCD, 1'b0));
    cmd_q.push_back(mk(OP_SET_TR, 8'd7, 8'd3, 16'hABCD, 1'b1));
    cmd_q.push_back(mk(OP_SET_TR, 8'd0, 8'd0, 16'h0000, 1'b1));
    cmd_q.push_back(mk(OP_SET_TR, 8'd7, 8'd7, 16'hFFFE, 1'b1));
    cmd_q.push_back(mk(OP_START, 8'd0, 8'd200, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_START, 8'd0, 8'd3, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_START, 8'd0, 8'd7, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_FINISH, 8'd0, 8'd0, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_FINISH, 8'd0, 8'd0, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_LIST, 8'd0, 8'd0, 16'd0, 1'b0));
    cmd_q.push_back(mk(OP_RSVD_6, 8'd1, 8'd1, 16'h0001, 1'b1));
    cmd_q.push_back(mk(OP_RSVD_7, 8'd1, 8'd1, 16'h0001, 1'b1));
    cmd_q.push_back(mk(OP_SET_TR, 8'd7, 8'd3, NOT_DEFINED_INDEX, 1'b0));
    cmd_q.push_back(mk(OP_LIST, 8'd0, 8'd0, 16'd0, 1'b0));
    wait_drained();

    write_startup(3'd0);
    add_random(80);
    pressure_req = 1'b1;
    wait_drained();

    write_startup(3'($urandom_range(1, 6)));
    add_random(70);
    wait_drained();

    write_startup(3'd7);
    add_random(70);
    wait_drained();

    repeat (20) @(posedge clk);
    if (expected_beats.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
